@@ src/hbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbr_pkg
// Shared types, constants and the speed validation function for the dual
// H-bridge speed ramp controller.
// ----------------------------------------------------------------------------
package hbr_pkg;

  localparam int SPEED_W = 8;
  localparam int REQ_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [SPEED_W-1:0] RAMP_STEP       = 8'd5;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 8'd255;
  localparam logic [SPEED_W-1:0] MIN_SPEED_RESET = 8'd50;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 1'd1;

  typedef enum logic [1:0] {
    FUNC_SET    = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DIR_STOP     = 2'd0,
    DIR_FORWARD  = 2'd1,
    DIR_BACKWARD = 2'd2,
    DIR_BRAKE    = 2'd3
  } dir_t;

  // command for one channel, issued as the command register retires
  typedef struct packed {
    logic               go;
    func_t              func;
    logic               hit;
    logic [SPEED_W-1:0] vspeed;
    dir_t               dir;
  } chan_cmd_t;

  // bridge drive of one channel
  typedef struct packed {
    logic [SPEED_W-1:0] duty;
    logic               in1;
    logic               in2;
    logic               running;
  } drive_t;

  // clamp a signed request to 0..max, then lift nonzero values to min
  function automatic logic [SPEED_W-1:0] validate_speed(
    input logic signed [REQ_W-1:0] req,
    input logic [SPEED_W-1:0]      max_spd,
    input logic [SPEED_W-1:0]      min_spd
  );
    logic [SPEED_W-1:0] v;
    if (req <= 0) begin
      v = '0;
    end else if (req > $signed({1'b0, {(REQ_W-SPEED_W-1){1'b0}}, max_spd})) begin
      v = max_spd;
    end else begin
      v = req[SPEED_W-1:0];
    end
    if ((v != '0) && (v < min_spd)) begin
      v = min_spd;
    end
    return v;
  endfunction

endpackage

@@ src/hbr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbr_if
// Valid/ready channels: command beats, drive result beats, register writes.
// ----------------------------------------------------------------------------
interface hbr_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic               motor;
  logic signed [15:0] speed;
  logic [1:0]         direction;
  modport source (output valid, func, motor, speed, direction, input ready);
  modport sink   (input valid, func, motor, speed, direction, output ready);
endinterface

interface hbr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_a;
  logic       in1_a;
  logic       in2_a;
  logic       running_a;
  logic [7:0] duty_b;
  logic       in1_b;
  logic       in2_b;
  logic       running_b;
  modport source (output valid, duty_a, in1_a, in2_a, running_a,
                  duty_b, in1_b, in2_b, running_b, input ready);
  modport sink   (input valid, duty_a, in1_a, in2_a, running_a,
                  duty_b, in1_b, in2_b, running_b, output ready);
endinterface

interface hbr_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/hbr_channel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbr_channel
// State of one motor channel: applied speed and direction, ramp speed and
// ramp target. Applies one command per beat and gives the resulting drive.
// ----------------------------------------------------------------------------
module hbr_channel (
  input  logic               clk,
  input  logic               rst,
  input  hbr_pkg::chan_cmd_t cmd,
  output hbr_pkg::drive_t    drive
);
  import hbr_pkg::*;

  logic [SPEED_W-1:0] applied_speed, applied_speed_next;
  dir_t               applied_dir, applied_dir_next;
  logic [SPEED_W-1:0] ramp_speed, ramp_speed_next;
  logic [SPEED_W-1:0] ramp_target, ramp_target_next;
  logic [SPEED_W-1:0] ramp_step;

  // step the ramp toward its target without overshoot
  always_comb begin
    if (ramp_speed < ramp_target) begin
      ramp_step = ((ramp_target - ramp_speed) > RAMP_STEP) ?
                  ramp_speed + RAMP_STEP : ramp_target;
    end else begin
      ramp_step = ((ramp_speed - ramp_target) > RAMP_STEP) ?
                  ramp_speed - RAMP_STEP : ramp_target;
    end
  end

  // select next state from the command
  always_comb begin
    applied_speed_next = applied_speed;
    applied_dir_next   = applied_dir;
    ramp_speed_next    = ramp_speed;
    ramp_target_next   = ramp_target;
    if (cmd.go) begin
      case (cmd.func)
        FUNC_SET: begin
          if (cmd.hit) begin
            applied_speed_next = cmd.vspeed;
            applied_dir_next   = cmd.dir;
          end
        end
        FUNC_TARGET: begin
          if (cmd.hit) begin
            ramp_target_next = cmd.vspeed;
          end
        end
        FUNC_TICK: begin
          if (ramp_speed != ramp_target) begin
            ramp_speed_next    = ramp_step;
            applied_speed_next = ramp_step;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // hold channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      applied_speed <= '0;
      applied_dir   <= DIR_STOP;
      ramp_speed    <= '0;
      ramp_target   <= '0;
    end else begin
      applied_speed <= applied_speed_next;
      applied_dir   <= applied_dir_next;
      ramp_speed    <= ramp_speed_next;
      ramp_target   <= ramp_target_next;
    end
  end

  // decode drive from the state this beat leaves behind
  always_comb begin
    drive.duty    = ((applied_dir_next == DIR_FORWARD) ||
                     (applied_dir_next == DIR_BACKWARD)) ? applied_speed_next : '0;
    drive.in1     = (applied_dir_next == DIR_FORWARD) || (applied_dir_next == DIR_BRAKE);
    drive.in2     = (applied_dir_next == DIR_BACKWARD) || (applied_dir_next == DIR_BRAKE);
    drive.running = (applied_speed_next != '0) && (applied_dir_next != DIR_STOP);
  end

  // state moves only on a retiring beat
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(cmd.go) |->
      $stable(applied_speed) && $stable(ramp_speed) && $stable(ramp_target))
    else $error("channel state changed without a command beat");

  // ramp never moves more than one step per beat
  a_ramp_bound: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      ((ramp_speed >= $past(ramp_speed)) ?
         (ramp_speed - $past(ramp_speed)) <= RAMP_STEP :
         ($past(ramp_speed) - ramp_speed) <= RAMP_STEP))
    else $error("ramp moved more than one step");

  // ramp keeps its side of the target on a tick
  a_no_overshoot: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(cmd.go) && ($past(cmd.func) == FUNC_TICK) &&
    ($past(ramp_speed) <= $past(ramp_target)) |-> ramp_speed <= ramp_target)
    else $error("ramp overshot its target");

endmodule

@@ src/dual_hbridge_speed_ramp_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_hbridge_speed_ramp_controller
// Two-channel H-bridge drive with direct speed set and slew-limited ramp.
// ----------------------------------------------------------------------------
// The block takes one command beat per clock while results are taken and
// returns one drive beat per command, reporting duty, bridge inputs and running
// flag of both motors. A command passes a command register and then a result
// register, which offers its result until taken; the sustained rate is one beat
// per cycle while results are taken, set by the combinational validate/ramp/
// decode path between the two registers. A stalled result holds the result
// register, and the command register keeps taking beats until both stages are
// full. Register writes (max_speed at index 0, min_speed at index 1) are always
// accepted and take effect on the next command to leave the command register.
module dual_hbridge_speed_ramp_controller (
  input logic      clk,
  input logic      rst,
  hbr_cmd_if.sink  cmd,
  hbr_res_if.source res,
  hbr_cfg_if.sink  cfg
);
  import hbr_pkg::*;

  logic [SPEED_W-1:0]      max_speed;
  logic [SPEED_W-1:0]      min_speed;
  logic                    s1_valid;
  func_t                   s1_func;
  logic                    s1_motor;
  logic signed [REQ_W-1:0] s1_speed;
  dir_t                    s1_dir;
  logic                    out_valid;
  drive_t                  out_a;
  drive_t                  out_b;
  logic                    advance;
  logic [SPEED_W-1:0]      vspeed;
  chan_cmd_t               cmd_a;
  chan_cmd_t               cmd_b;
  drive_t                  drive_a;
  drive_t                  drive_b;

  // write configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= MAX_SPEED_RESET;
      min_speed <= MIN_SPEED_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MAX_SPEED: max_speed <= cfg.data;
        CFG_MIN_SPEED: min_speed <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // advance the command register when the result register frees up
  assign advance   = s1_valid && (!out_valid || res.ready);
  assign cmd.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_func  <= func_t'(cmd.func);
      s1_motor <= cmd.motor;
      s1_speed <= cmd.speed;
      s1_dir   <= dir_t'(cmd.direction);
    end
  end

  // validate the request and fan the command out to both channels
  assign vspeed = validate_speed(s1_speed, max_speed, min_speed);

  always_comb begin
    cmd_a.go     = advance;
    cmd_a.func   = s1_func;
    cmd_a.hit    = !s1_motor;
    cmd_a.vspeed = vspeed;
    cmd_a.dir    = s1_dir;
    cmd_b        = cmd_a;
    cmd_b.hit    = s1_motor;
  end

  hbr_channel u_chan_a (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_a),
    .drive (drive_a)
  );

  hbr_channel u_chan_b (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_b),
    .drive (drive_b)
  );

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_a <= drive_a;
      out_b <= drive_b;
    end
  end

  assign res.valid     = out_valid;
  assign res.duty_a    = out_a.duty;
  assign res.in1_a     = out_a.in1;
  assign res.in2_a     = out_a.in2;
  assign res.running_a = out_a.running;
  assign res.duty_b    = out_b.duty;
  assign res.in1_b     = out_b.in1;
  assign res.in2_b     = out_b.in2;
  assign res.running_b = out_b.running;

endmodule
